// ----- rtl/ssit_pkg.sv -----
package ssit_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned IDX_BITS   = 10;
  localparam int unsigned COUNT_BITS = 9;

  // Status codes carried in every result beat.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_WRITE_VERTEX   = 2'd0,
    OP_APPEND_SEGMENT = 2'd1,
    OP_CLEAR_SEGMENTS = 2'd2,
    OP_QUERY_SEGMENT  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                          operation;
    logic [IDX_BITS-1:0]          vertex_index;
    logic [IDX_BITS-1:0]          from_vertex;
    logic [IDX_BITS-1:0]          to_vertex;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic                         status;
    logic [COUNT_BITS-1:0]        segment_count;
    logic signed [COORD_BITS-1:0] box_xmin;
    logic signed [COORD_BITS-1:0] box_xmax;
    logic signed [COORD_BITS-1:0] box_ymin;
    logic signed [COORD_BITS-1:0] box_ymax;
  } out_item_t;

  // Status of the intersection pipeline as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic hit;
  } isect_stat_t;

endpackage

// ----- rtl/ssit_in_if.sv -----
interface ssit_in_if;
  logic               valid;
  logic               ready;
  ssit_pkg::in_item_t data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ----- rtl/ssit_out_if.sv -----
interface ssit_out_if;
  logic                valid;
  logic                ready;
  ssit_pkg::out_item_t data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ----- rtl/ssit_ram.sv -----
module ssit_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ssit_isect.sv -----
module ssit_isect #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          seg_valid_i,
  input  logic [4*COORD_WIDTH-1:0]      seg_i,
  input  logic signed [COORD_WIDTH-1:0] x1_i,
  input  logic signed [COORD_WIDTH-1:0] y1_i,
  input  logic signed [COORD_WIDTH-1:0] x2_i,
  input  logic signed [COORD_WIDTH-1:0] y2_i,
  output ssit_pkg::isect_stat_t         stat_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;
  localparam logic signed [NW-1:0] ZERO = '0;

  logic signed [COORD_WIDTH-1:0] x3_w, y3_w, x4_w, y4_w;
  logic signed [DW-1:0] dx12_d, dy12_d, x13_d, y13_d, x34_d, y34_d;
  logic signed [DW-1:0] dx12_q, dy12_q, x13_q, y13_q, x34_q, y34_q;
  logic signed [PW-1:0] p1_d, p2_d, p3_d, p4_d, p5_d, p6_d;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [NW-1:0] den_d, tn_d, un_d;
  logic signed [NW-1:0] den_q, tn_q, un_q;
  logic                 a_valid_q, b_valid_q, c_valid_q;
  logic                 t_in_w, u_in_w;

  assign {x3_w, y3_w, x4_w, y4_w} = seg_i;

  // Stage A: coordinate differences of the query and the stored segment.
  assign dx12_d = DW'(x1_i) - DW'(x2_i);
  assign dy12_d = DW'(y1_i) - DW'(y2_i);
  assign x13_d  = DW'(x1_i) - DW'(x3_w);
  assign y13_d  = DW'(y1_i) - DW'(y3_w);
  assign x34_d  = DW'(x3_w) - DW'(x4_w);
  assign y34_d  = DW'(y3_w) - DW'(y4_w);

  // Stage B: the six cross products, each in a multiplier of its own.
  assign p1_d = PW'(dx12_q) * PW'(y34_q);
  assign p2_d = PW'(dy12_q) * PW'(x34_q);
  assign p3_d = PW'(x13_q) * PW'(y34_q);
  assign p4_d = PW'(y13_q) * PW'(x34_q);
  assign p5_d = PW'(dx12_q) * PW'(y13_q);
  assign p6_d = PW'(dy12_q) * PW'(x13_q);

  // Stage C: denominator and the two numerators.
  assign den_d = NW'(p1_q) - NW'(p2_q);
  assign tn_d  = NW'(p3_q) - NW'(p4_q);
  assign un_d  = NW'(p6_q) - NW'(p5_q);

  always_ff @(posedge clk_i) begin
    dx12_q <= dx12_d;
    dy12_q <= dy12_d;
    x13_q  <= x13_d;
    y13_q  <= y13_d;
    x34_q  <= x34_d;
    y34_q  <= y34_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    p3_q   <= p3_d;
    p4_q   <= p4_d;
    p5_q   <= p5_d;
    p6_q   <= p6_d;
    den_q  <= den_d;
    tn_q   <= tn_d;
    un_q   <= un_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= seg_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Range tests on t and u: each numerator lies between zero and the
  // denominator, endpoints included, whatever the sign of the denominator.
  assign t_in_w = den_q[NW-1] ? (den_q <= tn_q && tn_q <= ZERO)
                              : (tn_q >= ZERO && tn_q <= den_q);
  assign u_in_w = den_q[NW-1] ? (den_q <= un_q && un_q <= ZERO)
                              : (un_q >= ZERO && un_q <= den_q);

  assign stat_o.hit  = c_valid_q && (den_q != ZERO) && t_in_w && u_in_w;
  assign stat_o.busy = a_valid_q || b_valid_q || c_valid_q;

endmodule

// ----- rtl/segment_set_intersect_test.sv -----
// Segment-set intersection tester.
// One input channel (in_i) takes a beat per operation: write a vertex,
// append a segment built from two stored vertices, clear the segment
// table, or query whether a segment meets any stored segment. Every input
// beat produces exactly one result beat on out_o carrying the hit flag,
// the append status, the segment count and the bounding box of the
// stored segments.
// A vertex write, a clear or a query of an empty table goes straight to
// its result; an append reads its two vertices in turn and then writes
// the new row; a query reads the stored segments and waits for the
// pipeline to drain. The segment table is read one entry per cycle
// through a single memory port, which sets the query time; the cross
// products run in a three-stage pipeline.
// One item is worked on at a time, so no new input beat is taken before
// the last one is done; a new input beat is taken as soon as the previous
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds until it is taken, and the next finished result
// waits behind it, which blocks the input.
// Reset empties the segment table and sets the box to its empty extremes.
// The vertex store is not cleared and needs no clearing pass.
module segment_set_intersect_test #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssit_in_if.sink    in_i,
  ssit_out_if.source out_o
);

  localparam int unsigned VA       = $clog2(MAX_VERTICES);
  localparam int unsigned SA       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW       = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IDX_EXT  = 17;
  localparam int unsigned CNT_EXT  = 16;
  localparam int unsigned OUT_BITS = ssit_pkg::COORD_BITS;
  localparam int unsigned CNT_BITS = ssit_pkg::COUNT_BITS;

  localparam logic signed [COORD_WIDTH-1:0] BOX_TOP    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] BOX_BOTTOM = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_APP_RD0 = 3'd1;
  localparam logic [2:0] S_APP_RD1 = 3'd2;
  localparam logic [2:0] S_APP_WR  = 3'd3;
  localparam logic [2:0] S_Q_ISSUE = 3'd4;
  localparam logic [2:0] S_Q_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_acc_w;

  logic signed [COORD_WIDTH-1:0] fx_w, fy_w, sx_w, sy_w;
  logic [IDX_EXT-1:0]            vi_ext_w, fv_ext_w, tv_ext_w;
  logic                          vi_ok_w;
  logic [VA-1:0]                 fv_q, tv_q;
  logic                          fv_ok_q, tv_ok_q;

  logic signed [COORD_WIDTH-1:0] qx1_q, qy1_q, qx2_q, qy2_q;
  logic signed [COORD_WIDTH-1:0] ax_q, ay_q, ax_d, ay_d, bx_w, by_w;
  logic signed [COORD_WIDTH-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [COORD_WIDTH-1:0] xmin_d, xmax_d, ymin_d, ymax_d;
  logic [CW-1:0]                 count_q, count_d, k_q, k_d, k_next_w;
  logic                          hit_q, hit_d, status_q, status_d;
  logic                          rd_pend_q, rd_pend_d;

  logic                          vtx_we_w;
  logic [VA-1:0]                 vtx_raddr_w;
  logic [2*COORD_WIDTH-1:0]      vtx_rdata_w;
  logic                          seg_we_w;
  logic [4*COORD_WIDTH-1:0]      seg_rdata_w;

  ssit_pkg::isect_stat_t         stat_w;
  ssit_pkg::out_item_t           out_data_q, out_data_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_load_w;
  logic [CNT_EXT-1:0]            cnt_ext_w;

  // Input side: one item at a time, taken while the sequencer is idle.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc_w   = in_i.valid && in_i.ready;

  assign fx_w = in_i.data.first_x[COORD_WIDTH-1:0];
  assign fy_w = in_i.data.first_y[COORD_WIDTH-1:0];
  assign sx_w = in_i.data.second_x[COORD_WIDTH-1:0];
  assign sy_w = in_i.data.second_y[COORD_WIDTH-1:0];

  assign vi_ext_w = IDX_EXT'(in_i.data.vertex_index);
  assign fv_ext_w = IDX_EXT'(in_i.data.from_vertex);
  assign tv_ext_w = IDX_EXT'(in_i.data.to_vertex);
  assign vi_ok_w  = vi_ext_w < IDX_EXT'(MAX_VERTICES);

  // Vertex store: x in the upper half, y in the lower half of each word.
  assign vtx_we_w    = in_acc_w && (in_i.data.operation == ssit_pkg::OP_WRITE_VERTEX)
                       && vi_ok_w;
  assign vtx_raddr_w = (state_q == S_APP_RD0) ? fv_q : tv_q;

  ssit_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we_w),
    .waddr_i (vi_ext_w[VA-1:0]),
    .wdata_i ({fx_w, fy_w}),
    .raddr_i (vtx_raddr_w),
    .rdata_o (vtx_rdata_w)
  );

  // Endpoints of an appended segment; an index beyond the store reads zero.
  assign ax_d = fv_ok_q ? vtx_rdata_w[2*COORD_WIDTH-1:COORD_WIDTH] : '0;
  assign ay_d = fv_ok_q ? vtx_rdata_w[COORD_WIDTH-1:0] : '0;
  assign bx_w = tv_ok_q ? vtx_rdata_w[2*COORD_WIDTH-1:COORD_WIDTH] : '0;
  assign by_w = tv_ok_q ? vtx_rdata_w[COORD_WIDTH-1:0] : '0;

  // Segment table, one row of four coordinates per segment.
  assign seg_we_w = (state_q == S_APP_WR);

  ssit_ram #(
    .WIDTH (4 * COORD_WIDTH),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we_w),
    .waddr_i (count_q[SA-1:0]),
    .wdata_i ({ax_q, ay_q, bx_w, by_w}),
    .raddr_i (k_q[SA-1:0]),
    .rdata_o (seg_rdata_w)
  );

  ssit_isect #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_isect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_valid_i (rd_pend_q),
    .seg_i       (seg_rdata_w),
    .x1_i        (qx1_q),
    .y1_i        (qy1_q),
    .x2_i        (qx2_q),
    .y2_i        (qy2_q),
    .stat_o      (stat_w)
  );

  assign k_next_w   = k_q + CW'(1);
  assign out_load_w = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer and running state of the table.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    hit_d     = hit_q | stat_w.hit;
    status_d  = status_q;
    rd_pend_d = (state_q == S_Q_ISSUE);
    xmin_d    = xmin_q;
    xmax_d    = xmax_q;
    ymin_d    = ymin_q;
    ymax_d    = ymax_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc_w) begin
          hit_d    = 1'b0;
          status_d = ssit_pkg::STATUS_OK;
          state_d  = S_DONE;
          unique case (in_i.data.operation)
            ssit_pkg::OP_WRITE_VERTEX: begin
              state_d = S_DONE;
            end
            ssit_pkg::OP_APPEND_SEGMENT: begin
              if (count_q == CW'(MAX_SEGMENTS)) begin
                status_d = ssit_pkg::STATUS_FULL;
              end else begin
                state_d = S_APP_RD0;
              end
            end
            ssit_pkg::OP_CLEAR_SEGMENTS: begin
              count_d = '0;
              xmin_d  = BOX_TOP;
              ymin_d  = BOX_TOP;
              xmax_d  = BOX_BOTTOM;
              ymax_d  = BOX_BOTTOM;
            end
            ssit_pkg::OP_QUERY_SEGMENT: begin
              k_d = '0;
              if (count_q != '0) begin
                state_d = S_Q_ISSUE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_APP_RD0: begin
        state_d = S_APP_RD1;
      end
      S_APP_RD1: begin
        state_d = S_APP_WR;
      end
      S_APP_WR: begin
        count_d = count_q + CW'(1);
        if (ax_q < xmin_d) xmin_d = ax_q;
        if (bx_w < xmin_d) xmin_d = bx_w;
        if (ax_q > xmax_d) xmax_d = ax_q;
        if (bx_w > xmax_d) xmax_d = bx_w;
        if (ay_q < ymin_d) ymin_d = ay_q;
        if (by_w < ymin_d) ymin_d = by_w;
        if (ay_q > ymax_d) ymax_d = ay_q;
        if (by_w > ymax_d) ymax_d = by_w;
        state_d = S_DONE;
      end
      S_Q_ISSUE: begin
        k_d = k_next_w;
        if (k_next_w == count_q) begin
          state_d = S_Q_DRAIN;
        end
      end
      S_Q_DRAIN: begin
        if (!rd_pend_q && !stat_w.busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load_w) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      k_q       <= '0;
      hit_q     <= 1'b0;
      status_q  <= ssit_pkg::STATUS_OK;
      rd_pend_q <= 1'b0;
      xmin_q    <= BOX_TOP;
      ymin_q    <= BOX_TOP;
      xmax_q    <= BOX_BOTTOM;
      ymax_q    <= BOX_BOTTOM;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      k_q       <= k_d;
      hit_q     <= hit_d;
      status_q  <= status_d;
      rd_pend_q <= rd_pend_d;
      xmin_q    <= xmin_d;
      ymin_q    <= ymin_d;
      xmax_q    <= xmax_d;
      ymax_q    <= ymax_d;
    end
  end

  // Operands captured from the input beat and the first vertex read.
  always_ff @(posedge clk_i) begin
    if (in_acc_w) begin
      fv_q    <= fv_ext_w[VA-1:0];
      tv_q    <= tv_ext_w[VA-1:0];
      fv_ok_q <= fv_ext_w < IDX_EXT'(MAX_VERTICES);
      tv_ok_q <= tv_ext_w < IDX_EXT'(MAX_VERTICES);
      qx1_q   <= fx_w;
      qy1_q   <= fy_w;
      qx2_q   <= sx_w;
      qy2_q   <= sy_w;
    end
    if (state_q == S_APP_RD1) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  // Result register: loaded when the work is done and the slot is free or its beat is being taken.
  assign cnt_ext_w = CNT_EXT'(count_q);

  always_comb begin
    out_data_d               = out_data_q;
    out_data_d.hit           = hit_q;
    out_data_d.status        = status_q;
    out_data_d.segment_count = cnt_ext_w[CNT_BITS-1:0];
    out_data_d.box_xmin      = OUT_BITS'(xmin_q);
    out_data_d.box_xmax      = OUT_BITS'(xmax_q);
    out_data_d.box_ymin      = OUT_BITS'(ymin_q);
    out_data_d.box_ymax      = OUT_BITS'(ymax_q);
    out_valid_d              = out_valid_q && !out_o.ready;
    if (out_load_w) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_w) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- rtl/ssit_checker.sv -----
module ssit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  ssit_in_if.sink    in_i,
  ssit_out_if.source out_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_o.data))
    else $error("result payload changed while stalled");

  // A hit comes from a query and a full flag from an append, never both.
  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.data.hit && out_o.data.status))
    else $error("hit and full status in the same beat");

  // The box is empty in x exactly when it is empty in y.
  a_box_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.data.box_xmin > out_o.data.box_xmax) ==
                     (out_o.data.box_ymin > out_o.data.box_ymax)))
    else $error("bounding box empty in one axis only");

  // No result can appear in the cycle straight after an input beat.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !$rose(out_o.valid))
    else $error("result beat raised too early after an input beat");

endmodule

bind segment_set_intersect_test ssit_checker u_ssit_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// ----- bench/ssit_bench_pkg.sv -----
package ssit_bench_pkg;
  import ssit_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned VERTEX_DEPTH = 1024;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  // Wide enough that no cross product or difference of products can wrap.
  typedef logic signed [127:0] wide_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } boundary_seg_t;

  // Mirrors the vertex store, the segment table and the box, and holds the
  // result beats still owed by the block, oldest first.
  class intersect_scoreboard;
    coord_t        vertex_x [VERTEX_DEPTH];
    coord_t        vertex_y [VERTEX_DEPTH];
    boundary_seg_t boundary [TABLE_DEPTH];
    int unsigned   seg_count  = 0;
    coord_t        lo_x       = COORD_MAX;
    coord_t        hi_x       = COORD_MIN;
    coord_t        lo_y       = COORD_MAX;
    coord_t        hi_y       = COORD_MIN;
    out_item_t     awaited [$];
    int unsigned   mismatches = 0;

    task report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function int outstanding();
      return awaited.size();
    endfunction

    function void reset_box();
      lo_x = COORD_MAX;
      hi_x = COORD_MIN;
      lo_y = COORD_MAX;
      hi_y = COORD_MIN;
    endfunction

    function void widen_box(input coord_t x, input coord_t y);
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
    endfunction

    // True when num/den lies in [0, 1], endpoints included, without dividing.
    static function bit ratio_in_unit(input wide_t num, input wide_t den);
      if (den < 0) return (den <= num) && (num <= 0);
      return (num >= 0) && (num <= den);
    endfunction

    // Parametric test of the query segment against one stored segment.
    // A zero denominator (parallel, collinear or point-like) never meets.
    static function bit pair_meets(input coord_t x1, input coord_t y1,
                                   input coord_t x2, input coord_t y2,
                                   input boundary_seg_t s);
      wide_t dx12, dy12, dx13, dy13, dx34, dy34, den, t_num, u_num;
      dx12  = wide_t'(x1) - wide_t'(x2);
      dy12  = wide_t'(y1) - wide_t'(y2);
      dx13  = wide_t'(x1) - wide_t'(s.ax);
      dy13  = wide_t'(y1) - wide_t'(s.ay);
      dx34  = wide_t'(s.ax) - wide_t'(s.bx);
      dy34  = wide_t'(s.ay) - wide_t'(s.by);
      den   = dx12 * dy34 - dy12 * dx34;
      if (den == 0) return 1'b0;
      t_num = dx13 * dy34 - dy13 * dx34;
      u_num = -(dx12 * dy13 - dy12 * dx13);
      return ratio_in_unit(t_num, den) && ratio_in_unit(u_num, den);
    endfunction

    function bit query_hits(input coord_t x1, input coord_t y1,
                            input coord_t x2, input coord_t y2);
      for (int k = 0; k < seg_count; k++) begin
        if (pair_meets(x1, y1, x2, y2, boundary[k])) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Apply one accepted input beat and queue the result it must produce.
    function void note_operation(input in_item_t beat);
      out_item_t     outcome;
      boundary_seg_t seg;
      outcome        = '0;
      outcome.status = STATUS_OK;
      case (beat.operation)
        OP_WRITE_VERTEX: begin
          vertex_x[beat.vertex_index] = beat.first_x;
          vertex_y[beat.vertex_index] = beat.first_y;
        end
        OP_APPEND_SEGMENT: begin
          if (seg_count >= TABLE_DEPTH) begin
            outcome.status = STATUS_FULL;
          end else begin
            seg.ax = vertex_x[beat.from_vertex];
            seg.ay = vertex_y[beat.from_vertex];
            seg.bx = vertex_x[beat.to_vertex];
            seg.by = vertex_y[beat.to_vertex];
            boundary[seg_count] = seg;
            seg_count++;
            widen_box(seg.ax, seg.ay);
            widen_box(seg.bx, seg.by);
          end
        end
        OP_CLEAR_SEGMENTS: begin
          seg_count = 0;
          reset_box();
        end
        OP_QUERY_SEGMENT: begin
          outcome.hit = query_hits(beat.first_x, beat.first_y,
                                   beat.second_x, beat.second_y);
        end
        default: ;
      endcase
      outcome.segment_count = COUNT_BITS'(seg_count);
      outcome.box_xmin      = lo_x;
      outcome.box_xmax      = hi_x;
      outcome.box_ymin      = lo_y;
      outcome.box_ymax      = hi_y;
      awaited = {awaited, outcome};
    endfunction

    // Compare one result beat with the oldest outstanding expectation.
    task check_outcome(input out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", got));
        return;
      end
      want = awaited.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
      if (got.segment_count !== want.segment_count)
        report_mismatch($sformatf("segment_count %0d, expected %0d",
                                  got.segment_count, want.segment_count));
      if (got.box_xmin !== want.box_xmin)
        report_mismatch($sformatf("box_xmin %0d, expected %0d", got.box_xmin, want.box_xmin));
      if (got.box_xmax !== want.box_xmax)
        report_mismatch($sformatf("box_xmax %0d, expected %0d", got.box_xmax, want.box_xmax));
      if (got.box_ymin !== want.box_ymin)
        report_mismatch($sformatf("box_ymin %0d, expected %0d", got.box_ymin, want.box_ymin));
      if (got.box_ymax !== want.box_ymax)
        report_mismatch($sformatf("box_ymax %0d, expected %0d", got.box_ymax, want.box_ymax));
    endtask
  endclass

endpackage

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssit_pkg::*;
  import ssit_bench_pkg::*;

  localparam int unsigned CLK_PERIOD_NS = 4;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned RANDOM_BEATS  = 720;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned STALL_AFTER   = 850;
  localparam int unsigned STALL_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  logic clk_i    = 1'b0;
  logic rst_ni   = 1'b0;
  logic hold_off = 1'b0;

  ssit_in_if  in_bus ();
  ssit_out_if out_bus ();

  intersect_scoreboard sb;

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 66;
  int unsigned beats_sent    = 0;
  int unsigned cycle_count   = 0;

  // Vertices the stimulus has written, so that no append reads an empty slot.
  coord_t      known_x [VERTEX_DEPTH];
  coord_t      known_y [VERTEX_DEPTH];
  bit          is_written [VERTEX_DEPTH];
  int unsigned written_list [$];

  segment_set_intersect_test #(
    .MAX_SEGMENTS(TABLE_DEPTH),
    .MAX_VERTICES(VERTEX_DEPTH),
    .COORD_WIDTH (COORD_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #(CLK_PERIOD_NS / 2.0) clk_i = ~clk_i;

  // Offer one beat from a falling edge and hold it until it is taken.
  task automatic drive_beat(input in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= beat;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_operation(beat);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Fields that the operation ignores still carry random bits.
  function automatic in_item_t scrambled_beat(input op_e op);
    in_item_t beat;
    beat.operation    = op;
    beat.vertex_index = IDX_BITS'($urandom);
    beat.from_vertex  = IDX_BITS'($urandom);
    beat.to_vertex    = IDX_BITS'($urandom);
    beat.first_x      = coord_t'($urandom);
    beat.first_y      = coord_t'($urandom);
    beat.second_x     = coord_t'($urandom);
    beat.second_y     = coord_t'($urandom);
    return beat;
  endfunction

  function automatic coord_t grid(input int units);
    return coord_t'(units * 65536);
  endfunction

  // Mix of full-range values, a coarse grid that gives collinear and
  // touching cases, the extremes, and points one LSB off the grid.
  function automatic coord_t random_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return grid(int'($urandom_range(16)) - 8);
      2: begin
        case ($urandom_range(4))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return coord_t'(0);
          3:       return coord_t'(1);
          default: return coord_t'(-1);
        endcase
      end
      default: return grid(int'($urandom_range(16)) - 8) + coord_t'(int'($urandom_range(2)) - 1);
    endcase
  endfunction

  function automatic int unsigned pick_vertex();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic send_write(input int unsigned idx, input coord_t x, input coord_t y);
    in_item_t beat;
    beat              = scrambled_beat(OP_WRITE_VERTEX);
    beat.vertex_index = IDX_BITS'(idx);
    beat.first_x      = x;
    beat.first_y      = y;
    known_x[idx]      = x;
    known_y[idx]      = y;
    if (!is_written[idx]) begin
      is_written[idx] = 1'b1;
      written_list    = {written_list, idx};
    end
    drive_beat(beat);
  endtask

  task automatic send_append(input int unsigned from_idx, input int unsigned to_idx);
    in_item_t beat;
    beat             = scrambled_beat(OP_APPEND_SEGMENT);
    beat.from_vertex = IDX_BITS'(from_idx);
    beat.to_vertex   = IDX_BITS'(to_idx);
    drive_beat(beat);
  endtask

  task automatic send_clear();
    drive_beat(scrambled_beat(OP_CLEAR_SEGMENTS));
  endtask

  task automatic send_query(input coord_t x0, input coord_t y0,
                            input coord_t x1, input coord_t y1);
    in_item_t beat;
    beat          = scrambled_beat(OP_QUERY_SEGMENT);
    beat.first_x  = x0;
    beat.first_y  = y0;
    beat.second_x = x1;
    beat.second_y = y1;
    drive_beat(beat);
  endtask

  // Hand-picked geometry: crossings, touching ends, parallel and collinear
  // pairs, point-like segments, the coordinate extremes and the clear.
  task automatic directed_checks();
    send_query(grid(-1), grid(0), grid(1), grid(0));
    send_write(0, grid(0), grid(0));
    send_write(1, grid(4), grid(4));
    send_write(2, grid(0), grid(4));
    send_write(3, grid(4), grid(0));
    send_write(1023, COORD_MAX, COORD_MAX);
    send_write(512, COORD_MIN, COORD_MIN);
    send_append(0, 1);
    send_query(grid(0), grid(4), grid(4), grid(0));
    send_query(grid(4), grid(4), grid(8), grid(0));
    send_query(grid(0), grid(1), grid(4), grid(5));
    send_query(grid(0), grid(0), grid(2), grid(2));
    send_query(grid(1), grid(1), grid(1), grid(1));
    send_query(grid(0), grid(4), grid(2) - coord_t'(1), grid(2) + coord_t'(1));
    send_query(grid(0), grid(4), grid(2), grid(2));
    send_append(2, 2);
    send_append(512, 1023);
    send_query(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    send_append(1023, 512);
    send_clear();
    send_query(grid(0), grid(4), grid(4), grid(0));
    send_append(3, 2);
    send_query(grid(0), grid(0), grid(4), grid(4));
    send_clear();
  endtask

  // Fill the table to the brim, then push appends that must be refused.
  task automatic fill_table();
    send_clear();
    for (int n = 1; n <= TABLE_DEPTH + 2; n++) begin
      send_append(pick_vertex(), pick_vertex());
      if (n % 64 == 0 || n > TABLE_DEPTH)
        send_query(random_coord(), random_coord(), random_coord(), random_coord());
    end
    send_clear();
  endtask

  // Mostly well-formed traffic: appends only use written vertices, and
  // many queries run between stored vertices so that ends coincide.
  task automatic random_step();
    int unsigned pick;
    int unsigned v0;
    int unsigned v1;
    pick = (written_list.size() == 0) ? 0 : $urandom_range(99);
    if (pick < 28) begin
      v0 = $urandom_range(1) ? $urandom_range(15) : $urandom_range(VERTEX_DEPTH - 1);
      send_write(v0, random_coord(), random_coord());
    end else if (pick < 60) begin
      send_append(pick_vertex(), pick_vertex());
    end else if (pick < 64) begin
      send_clear();
    end else if (pick < 78) begin
      v0 = pick_vertex();
      v1 = pick_vertex();
      send_query(known_x[v0], known_y[v0], known_x[v1], known_y[v1]);
    end else if (pick < 86) begin
      v0 = pick_vertex();
      send_query(known_x[v0], known_y[v0], random_coord(), random_coord());
    end else begin
      send_query(random_coord(), random_coord(), random_coord(), random_coord());
    end
  endtask

  // Receiver: ready is redrawn at every falling edge.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long receiver hold-off, so that the block backs up into its input.
  initial begin
    wait (beats_sent >= STALL_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Result beats are checked as they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_outcome(out_bus.data);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed beats, a table fill, then three random stages.
  initial begin
    sb           = new;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_checks();
    for (int stage = 0; stage < 3; stage++) begin
      if (stage == 1) begin
        send_idle_pct <= 66;
        recv_idle_pct <= 16;
      end else if (stage == 2) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (stage == 0) fill_table();
      repeat (RANDOM_BEATS / 3) random_step();
    end
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ssit_pkg.sv
rtl/ssit_in_if.sv
rtl/ssit_out_if.sv
rtl/ssit_ram.sv
rtl/ssit_isect.sv
rtl/segment_set_intersect_test.sv
rtl/ssit_checker.sv
bench/ssit_bench_pkg.sv
bench/tb.sv
